// ----- hdl/tpss_pkg.sv -----
// ============================================================================
// tpss_pkg
// Shared types and constants of the two-point settle sequencer.
// ============================================================================
`default_nettype none

package tpss_pkg;

    localparam logic [31:0] TICK_MS = 32'd5;

    // configuration register indexes
    localparam logic [2:0] REG_FIRST_TARGET       = 3'd0;
    localparam logic [2:0] REG_SECOND_TARGET      = 3'd1;
    localparam logic [2:0] REG_POSITION_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT        = 3'd3;
    localparam logic [2:0] REG_SETTLE_TIME_MS     = 3'd4;
    localparam logic [2:0] REG_SETTLE_MIN_SAMPLES = 3'd5;
    localparam logic [2:0] REG_PHASE_TIMEOUT_MS   = 3'd6;

    // reset values
    localparam logic signed [15:0] RST_FIRST_TARGET       = 16'sd800;
    localparam logic signed [15:0] RST_SECOND_TARGET      = -16'sd800;
    localparam logic [15:0]        RST_POSITION_TOLERANCE = 16'd160;
    localparam logic [18:0]        RST_SPEED_LIMIT        = 19'd160;
    localparam logic [15:0]        RST_SETTLE_TIME_MS     = 16'd500;
    localparam logic [7:0]         RST_SETTLE_MIN_SAMPLES = 8'd4;
    localparam logic [31:0]        RST_PHASE_TIMEOUT_MS   = 32'd8000;

    localparam logic [7:0] SETTLE_COUNT_MAX = 8'd255;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // task_phase output codes
    localparam logic [2:0] PHASE_CODE_IDLE   = 3'd0;
    localparam logic [2:0] PHASE_CODE_FIRST  = 3'd1;
    localparam logic [2:0] PHASE_CODE_SECOND = 3'd2;
    localparam logic [2:0] PHASE_CODE_DONE   = 3'd3;
    localparam logic [2:0] PHASE_CODE_FAULT  = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_SECOND = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAULT  = 5'b10000
    } phase_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        code = PHASE_CODE_IDLE;
        unique case (ph)
            PH_IDLE:   code = PHASE_CODE_IDLE;
            PH_FIRST:  code = PHASE_CODE_FIRST;
            PH_SECOND: code = PHASE_CODE_SECOND;
            PH_DONE:   code = PHASE_CODE_DONE;
            PH_FAULT:  code = PHASE_CODE_FAULT;
            default:   code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tpss_if.sv -----
// ============================================================================
// tpss_if
// Item and result channels of the two-point settle sequencer.
// ============================================================================
`default_nettype none

interface tpss_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic               calibration_busy;
    logic               sample_valid;
    logic signed [15:0] sample_position;
    logic [31:0]        sample_stamp;
    logic signed [19:0] sample_velocity;

    modport source (
        output valid, cmd, calibration_busy, sample_valid,
               sample_position, sample_stamp, sample_velocity,
        input  ready
    );
    modport sink (
        input  valid, cmd, calibration_busy, sample_valid,
               sample_position, sample_stamp, sample_velocity,
        output ready
    );
endinterface

interface tpss_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         task_phase;
    logic               setpoint_write;
    logic signed [15:0] setpoint_value;
    logic [31:0]        run_time_ms;
    logic [15:0]        peak_error_first;
    logic [15:0]        peak_error_second;

    modport source (
        output valid, task_phase, setpoint_write, setpoint_value,
               run_time_ms, peak_error_first, peak_error_second,
        input  ready
    );
    modport sink (
        input  valid, task_phase, setpoint_write, setpoint_value,
               run_time_ms, peak_error_first, peak_error_second,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/two_point_settle_sequencer.sv -----
// ============================================================================
// two_point_settle_sequencer
// Runs a positioning task to two setpoints with timeout, settle window and
// per-phase peak error tracking.
// ============================================================================
// channel   dir   beat
// item      in    start request or tick with position/velocity sample
// result    out   phase, setpoint, run time, peak errors (one per item)
// cfg       in    register write, index 0..6, no read-back
//
// An item passes the input register, then the result register, on its way
// from item beat to result beat. One item per cycle sustained; both stages
// advance whenever the result register is empty or being taken. Sequencer
// state updates as an item moves from the input into the result register.
// rst_n clears control state and loads the register reset values.
// ============================================================================
`default_nettype none

module two_point_settle_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    tpss_item_if.sink        item,
    tpss_result_if.source    result
);

    // configuration
    logic signed [15:0] first_target_reg;
    logic signed [15:0] second_target_reg;
    logic [15:0]        position_tolerance_reg;
    logic [18:0]        speed_limit_reg;
    logic [15:0]        settle_time_ms_reg;
    logic [7:0]         settle_min_samples_reg;
    logic [31:0]        phase_timeout_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_target_reg       <= tpss_pkg::RST_FIRST_TARGET;
            second_target_reg      <= tpss_pkg::RST_SECOND_TARGET;
            position_tolerance_reg <= tpss_pkg::RST_POSITION_TOLERANCE;
            speed_limit_reg        <= tpss_pkg::RST_SPEED_LIMIT;
            settle_time_ms_reg     <= tpss_pkg::RST_SETTLE_TIME_MS;
            settle_min_samples_reg <= tpss_pkg::RST_SETTLE_MIN_SAMPLES;
            phase_timeout_ms_reg   <= tpss_pkg::RST_PHASE_TIMEOUT_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpss_pkg::REG_FIRST_TARGET:       first_target_reg <= cfg_data[15:0];
                tpss_pkg::REG_SECOND_TARGET:      second_target_reg <= cfg_data[15:0];
                tpss_pkg::REG_POSITION_TOLERANCE: position_tolerance_reg <= cfg_data[15:0];
                tpss_pkg::REG_SPEED_LIMIT:        speed_limit_reg <= cfg_data[18:0];
                tpss_pkg::REG_SETTLE_TIME_MS:     settle_time_ms_reg <= cfg_data[15:0];
                tpss_pkg::REG_SETTLE_MIN_SAMPLES: settle_min_samples_reg <= cfg_data[7:0];
                tpss_pkg::REG_PHASE_TIMEOUT_MS:   phase_timeout_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // input register
    logic               cmd_reg;
    logic               busy_reg;
    logic               svalid_reg;
    logic signed [15:0] pos_reg;
    logic [31:0]        stamp_reg;
    logic signed [19:0] vel_reg;

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg    <= item.cmd;
            busy_reg   <= item.calibration_busy;
            svalid_reg <= item.sample_valid;
            pos_reg    <= item.sample_position;
            stamp_reg  <= item.sample_stamp;
            vel_reg    <= item.sample_velocity;
        end
    end

    // sequencer state
    tpss_pkg::phase_t   phase_reg, phase_next;
    logic [31:0]        time_now_reg, time_now_next;
    logic [31:0]        run_start_reg, run_start_next;
    logic [31:0]        phase_start_reg, phase_start_next;
    logic [31:0]        settle_start_reg, settle_start_next;
    logic [31:0]        last_stamp_reg, last_stamp_next;
    logic [7:0]         settle_count_reg, settle_count_next;
    logic               armed_reg, armed_next;
    logic [31:0]        total_time_reg, total_time_next;
    logic [15:0]        peak_first_reg, peak_first_next;
    logic [15:0]        peak_second_reg, peak_second_next;
    logic signed [15:0] setpoint_reg, setpoint_next;
    logic               wr_next;

    logic signed [16:0] diff;
    logic [16:0]        diff_abs;
    logic [15:0]        err;
    logic [19:0]        vel_abs;
    logic [31:0]        tn;
    logic [31:0]        settled_for;

    always_comb
    begin
        phase_next        = phase_reg;
        time_now_next     = time_now_reg;
        run_start_next    = run_start_reg;
        phase_start_next  = phase_start_reg;
        settle_start_next = settle_start_reg;
        last_stamp_next   = last_stamp_reg;
        settle_count_next = settle_count_reg;
        armed_next        = armed_reg;
        total_time_next   = total_time_reg;
        peak_first_next   = peak_first_reg;
        peak_second_next  = peak_second_reg;
        setpoint_next     = setpoint_reg;
        wr_next           = 1'b0;
        tn                = time_now_reg + tpss_pkg::TICK_MS;
        diff              = 17'sd0;
        diff_abs          = 17'd0;
        err               = 16'd0;
        vel_abs           = vel_reg[19] ? 20'(-vel_reg) : vel_reg;
        settled_for       = 32'd0;

        if (cmd_reg == tpss_pkg::CMD_START)
        begin
            if (!busy_reg && (phase_reg == tpss_pkg::PH_IDLE ||
                              phase_reg == tpss_pkg::PH_DONE ||
                              phase_reg == tpss_pkg::PH_FAULT))
            begin
                phase_next        = tpss_pkg::PH_FIRST;
                run_start_next    = time_now_reg;
                total_time_next   = 32'd0;
                armed_next        = 1'b0;
                settle_start_next = 32'd0;
                last_stamp_next   = 32'd0;
                settle_count_next = 8'd0;
                peak_first_next   = 16'd0;
                peak_second_next  = 16'd0;
            end
        end
        else
        begin
            time_now_next = tn;
            if (phase_reg == tpss_pkg::PH_FIRST || phase_reg == tpss_pkg::PH_SECOND)
            begin
                if (!armed_reg)
                begin
                    setpoint_next     = (phase_reg == tpss_pkg::PH_FIRST) ?
                                        first_target_reg : second_target_reg;
                    wr_next           = 1'b1;
                    armed_next        = 1'b1;
                    phase_start_next  = tn;
                    settle_start_next = 32'd0;
                    last_stamp_next   = stamp_reg;
                    settle_count_next = 8'd0;
                end

                if ((tn - phase_start_next) > phase_timeout_ms_reg)
                begin
                    setpoint_next = 16'sd0;
                    wr_next       = 1'b1;
                    phase_next    = tpss_pkg::PH_FAULT;
                end
                else if (svalid_reg && stamp_reg != last_stamp_next)
                begin
                    last_stamp_next = stamp_reg;
                    diff     = {pos_reg[15], pos_reg} - {setpoint_next[15], setpoint_next};
                    diff_abs = diff[16] ? 17'(-diff) : diff;
                    err      = diff_abs[15:0];

                    if (phase_reg == tpss_pkg::PH_FIRST)
                    begin
                        if (err > peak_first_reg)
                            peak_first_next = err;
                        if (err <= position_tolerance_reg)
                        begin
                            phase_next        = tpss_pkg::PH_SECOND;
                            armed_next        = 1'b0;
                            settle_start_next = 32'd0;
                            settle_count_next = 8'd0;
                        end
                    end
                    else
                    begin
                        if (err > peak_second_reg)
                            peak_second_next = err;
                        if (err <= position_tolerance_reg &&
                            vel_abs <= {1'b0, speed_limit_reg})
                        begin
                            if (settle_count_next == 8'd0)
                                settle_start_next = tn;
                            if (settle_count_next < tpss_pkg::SETTLE_COUNT_MAX)
                                settle_count_next = settle_count_next + 8'd1;
                            settled_for = tn - settle_start_next;
                            if (settled_for >= {16'd0, settle_time_ms_reg} &&
                                settle_count_next >= settle_min_samples_reg)
                            begin
                                total_time_next = tn - run_start_reg;
                                phase_next      = tpss_pkg::PH_DONE;
                            end
                        end
                        else
                        begin
                            settle_start_next = 32'd0;
                            settle_count_next = 8'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= tpss_pkg::PH_IDLE;
            time_now_reg     <= 32'd0;
            run_start_reg    <= 32'd0;
            phase_start_reg  <= 32'd0;
            settle_start_reg <= 32'd0;
            last_stamp_reg   <= 32'd0;
            settle_count_reg <= 8'd0;
            armed_reg        <= 1'b0;
            total_time_reg   <= 32'd0;
            peak_first_reg   <= 16'd0;
            peak_second_reg  <= 16'd0;
            setpoint_reg     <= 16'sd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            time_now_reg     <= time_now_next;
            run_start_reg    <= run_start_next;
            phase_start_reg  <= phase_start_next;
            settle_start_reg <= settle_start_next;
            last_stamp_reg   <= last_stamp_next;
            settle_count_reg <= settle_count_next;
            armed_reg        <= armed_next;
            total_time_reg   <= total_time_next;
            peak_first_reg   <= peak_first_next;
            peak_second_reg  <= peak_second_next;
            setpoint_reg     <= setpoint_next;
        end
    end

    // result register
    logic [2:0]         task_phase_reg;
    logic               setpoint_write_reg;
    logic signed [15:0] setpoint_value_reg;
    logic [31:0]        run_time_ms_reg;
    logic [15:0]        peak_error_first_reg;
    logic [15:0]        peak_error_second_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            task_phase_reg        <= tpss_pkg::phase_code(phase_next);
            setpoint_write_reg    <= wr_next;
            setpoint_value_reg    <= setpoint_next;
            run_time_ms_reg       <= total_time_next;
            peak_error_first_reg  <= peak_first_next;
            peak_error_second_reg <= peak_second_next;
        end
    end

    assign result.task_phase        = task_phase_reg;
    assign result.setpoint_write    = setpoint_write_reg;
    assign result.setpoint_value    = setpoint_value_reg;
    assign result.run_time_ms       = run_time_ms_reg;
    assign result.peak_error_first  = peak_error_first_reg;
    assign result.peak_error_second = peak_error_second_reg;

endmodule

`default_nettype wire

// ----- tb/tb_two_point_settle_sequencer.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_two_point_settle_sequencer
// Self-checking bench for the two-point settle sequencer. Start and tick
// beats go in over the item channel. A behavioral copy of the sequencer
// predicts each status beat, and every status beat that comes out is checked
// field by field. Directed tests come first, then randomized runs under
// varied limits, random gaps, stalls and a long output hold.
// ============================================================================

module tb_two_point_settle_sequencer;

    typedef struct {
        logic               cmd;
        logic               busy;
        logic               valid;
        logic signed [15:0] pos;
        logic [31:0]        stamp;
        logic signed [19:0] vel;
    } sample_beat_t;

    typedef struct {
        logic [2:0]         phase;
        logic               write;
        logic signed [15:0] setpoint;
        logic [31:0]        run_time;
        logic [15:0]        peak_first;
        logic [15:0]        peak_second;
    } status_t;

    typedef struct {
        logic signed [15:0] first_pos;
        logic signed [15:0] second_pos;
        logic [15:0]        tol;
        logic [18:0]        speed;
        logic [15:0]        dwell_ms;
        logic [7:0]         min_samples;
        logic [31:0]        timeout_ms;
    } limits_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    tpss_item_if   item_ch();
    tpss_result_if result_ch();

    two_point_settle_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // sequencer copy
    limits_t            lim;
    logic [2:0]         sq_phase;
    logic [31:0]        sq_time;
    logic [31:0]        sq_run_start;
    logic [31:0]        sq_phase_start;
    logic [31:0]        sq_settle_start;
    logic [31:0]        sq_last_stamp;
    logic [7:0]         sq_settle_cnt;
    logic               sq_armed;
    logic [31:0]        sq_run_time;
    logic [15:0]        sq_peak1;
    logic [15:0]        sq_peak2;
    logic signed [15:0] sq_setpoint;

    status_t     pending_status[$];
    logic [31:0] stamp_ctr;
    bit          idle_on;
    int          hold_request;
    int          n_items;
    int          n_results;
    int          n_mismatch;
    int          n_done;
    int          n_fault;
    int          n_ignored;
    int          n_cfg_sets;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int clamp(input int x, input int lo, input int hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic int abs_int(input int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic run_tick(input sample_beat_t b);
        int          err;
        int          vabs;
        logic [31:0] held;
        logic        wr;
        wr = 1'b0;
        sq_time = sq_time + tpss_pkg::TICK_MS;
        if (sq_phase != tpss_pkg::PHASE_CODE_FIRST && sq_phase != tpss_pkg::PHASE_CODE_SECOND)
            return wr;
        if (!sq_armed) begin
            sq_setpoint = (sq_phase == tpss_pkg::PHASE_CODE_FIRST) ?
                          lim.first_pos : lim.second_pos;
            wr = 1'b1;
            sq_armed = 1'b1;
            sq_phase_start = sq_time;
            sq_settle_start = '0;
            sq_last_stamp = b.stamp;
            sq_settle_cnt = '0;
        end
        if (sq_time - sq_phase_start > lim.timeout_ms) begin
            sq_setpoint = '0;
            sq_phase = tpss_pkg::PHASE_CODE_FAULT;
            n_fault++;
            return 1'b1;
        end
        if (!b.valid || b.stamp == sq_last_stamp)
            return wr;
        sq_last_stamp = b.stamp;
        err = abs_int(int'($signed(b.pos)) - int'(sq_setpoint));
        if (sq_phase == tpss_pkg::PHASE_CODE_FIRST) begin
            if (err > int'(sq_peak1))
                sq_peak1 = err[15:0];
            if (err <= int'(lim.tol)) begin
                sq_phase = tpss_pkg::PHASE_CODE_SECOND;
                sq_armed = 1'b0;
                sq_settle_start = '0;
                sq_settle_cnt = '0;
            end
            return wr;
        end
        if (err > int'(sq_peak2))
            sq_peak2 = err[15:0];
        vabs = abs_int(int'($signed(b.vel)));
        if (err <= int'(lim.tol) && vabs <= int'(lim.speed)) begin
            if (sq_settle_cnt == '0)
                sq_settle_start = sq_time;
            if (sq_settle_cnt < tpss_pkg::SETTLE_COUNT_MAX)
                sq_settle_cnt = sq_settle_cnt + 8'd1;
            held = sq_time - sq_settle_start;
            if (held >= {16'd0, lim.dwell_ms} && sq_settle_cnt >= lim.min_samples) begin
                sq_run_time = sq_time - sq_run_start;
                sq_phase = tpss_pkg::PHASE_CODE_DONE;
                n_done++;
            end
        end else begin
            sq_settle_start = '0;
            sq_settle_cnt = '0;
        end
        return wr;
    endfunction

    function automatic status_t sequence_step(input sample_beat_t b);
        status_t s;
        logic    wr;
        wr = 1'b0;
        if (b.cmd == tpss_pkg::CMD_START) begin
            if (!b.busy && (sq_phase == tpss_pkg::PHASE_CODE_IDLE ||
                            sq_phase == tpss_pkg::PHASE_CODE_DONE ||
                            sq_phase == tpss_pkg::PHASE_CODE_FAULT)) begin
                sq_phase = tpss_pkg::PHASE_CODE_FIRST;
                sq_run_start = sq_time;
                sq_run_time = '0;
                sq_armed = 1'b0;
                sq_settle_start = '0;
                sq_last_stamp = '0;
                sq_settle_cnt = '0;
                sq_peak1 = '0;
                sq_peak2 = '0;
            end else begin
                n_ignored++;
            end
        end else begin
            wr = run_tick(b);
        end
        s.phase = sq_phase;
        s.write = wr;
        s.setpoint = sq_setpoint;
        s.run_time = sq_run_time;
        s.peak_first = sq_peak1;
        s.peak_second = sq_peak2;
        return s;
    endfunction

    function automatic sample_beat_t start_beat(input logic busy);
        sample_beat_t b;
        b.cmd = tpss_pkg::CMD_START;
        b.busy = busy;
        b.valid = 1'($urandom_range(0, 1));
        b.pos = 16'($urandom);
        b.stamp = $urandom;
        b.vel = 20'($urandom);
        return b;
    endfunction

    function automatic sample_beat_t tick_beat(input logic valid, input int pos,
                                               input logic [31:0] stamp, input int vel);
        sample_beat_t b;
        b.cmd = tpss_pkg::CMD_TICK;
        b.busy = 1'($urandom_range(0, 1));
        b.valid = valid;
        b.pos = pos[15:0];
        b.stamp = stamp;
        b.vel = vel[19:0];
        return b;
    endfunction

    // mostly well-formed runs steered by the predicted phase, some noise
    function automatic sample_beat_t make_beat(input int noise_pct);
        sample_beat_t b;
        int           tgt;
        int           span;
        int           off;
        int           vspan;
        int           vel;
        int           pick;
        if ($urandom_range(0, 99) < noise_pct) begin
            b = start_beat(1'($urandom_range(0, 1)));
            b.cmd = 1'($urandom_range(0, 1));
            return b;
        end
        if (sq_phase != tpss_pkg::PHASE_CODE_FIRST && sq_phase != tpss_pkg::PHASE_CODE_SECOND)
            return start_beat($urandom_range(0, 9) == 0);
        if (sq_armed)
            tgt = int'(sq_setpoint);
        else
            tgt = (sq_phase == tpss_pkg::PHASE_CODE_FIRST) ? int'(lim.first_pos) :
                                                             int'(lim.second_pos);
        span = int'(lim.tol);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            off = int'($urandom_range(0, 2 * span)) - span;
        else if (pick < 9)
            off = int'($urandom_range(0, 4 * span + 128)) - (2 * span + 64);
        else
            off = int'($signed(16'($urandom))) - tgt;
        vspan = int'(lim.speed);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            vel = int'($urandom_range(0, 2 * vspan)) - vspan;
        else if (pick < 9)
            vel = int'($urandom_range(0, 4 * vspan + 200)) - (2 * vspan + 100);
        else
            vel = int'($signed(20'($urandom)));
        if ($urandom_range(0, 15) != 0)
            stamp_ctr = stamp_ctr + $urandom_range(1, 25);
        return tick_beat($urandom_range(0, 15) != 0, clamp(tgt + off, -32768, 32767),
                         ($urandom_range(0, 15) == 0) ? sq_last_stamp : stamp_ctr,
                         clamp(vel, -524288, 524287));
    endfunction

    task automatic send_beat(input sample_beat_t b);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.cmd              <= b.cmd;
        item_ch.calibration_busy <= b.busy;
        item_ch.sample_valid     <= b.valid;
        item_ch.sample_position  <= b.pos;
        item_ch.sample_stamp     <= b.stamp;
        item_ch.sample_velocity  <= b.vel;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_status.push_back(sequence_step(b));
        n_items++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limits(input limits_t l);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= tpss_pkg::REG_FIRST_TARGET;
        cfg_data  <= {16'd0, l.first_pos};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_SECOND_TARGET;
        cfg_data  <= {16'd0, l.second_pos};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_POSITION_TOLERANCE;
        cfg_data  <= {16'd0, l.tol};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_SPEED_LIMIT;
        cfg_data  <= {13'd0, l.speed};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_SETTLE_TIME_MS;
        cfg_data  <= {16'd0, l.dwell_ms};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_SETTLE_MIN_SAMPLES;
        cfg_data  <= {24'd0, l.min_samples};
        @(posedge clk);
        cfg_index <= tpss_pkg::REG_PHASE_TIMEOUT_MS;
        cfg_data  <= l.timeout_ms;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim = l;
        n_cfg_sets++;
    endtask

    function automatic limits_t pick_limits();
        limits_t l;
        l.first_pos   = 16'($urandom);
        l.second_pos  = 16'($urandom);
        l.tol         = 16'($urandom_range(0, 400));
        l.speed       = 19'($urandom_range(0, 600));
        l.dwell_ms    = 16'($urandom_range(0, 60));
        l.min_samples = 8'($urandom_range(0, 6));
        l.timeout_ms  = $urandom_range(40, 800);
        return l;
    endfunction

    function automatic limits_t directed_limits(input logic [15:0] dwell_ms,
                                                input logic [7:0] min_samples,
                                                input logic [31:0] timeout_ms);
        limits_t l;
        l.first_pos   = 16'sd32767;
        l.second_pos  = -16'sd32768;
        l.tol         = 16'd160;
        l.speed       = 19'd524287;
        l.dwell_ms    = dwell_ms;
        l.min_samples = min_samples;
        l.timeout_ms  = timeout_ms;
        return l;
    endfunction

    task automatic drive_runs(input int count, input int noise_pct);
        for (int k = 0; k < count; k++)
            send_beat(make_beat(noise_pct));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_start_gating();
        send_beat(tick_beat(1'b1, 0, 32'd50, 0));
        send_beat(start_beat(1'b1));
        send_beat(start_beat(1'b0));
        send_beat(start_beat(1'b0));
    endtask

    task automatic test_first_target();
        send_beat(tick_beat(1'b1, 0, 32'd100, 0));
        send_beat(tick_beat(1'b0, 0, 32'd101, 0));
        send_beat(tick_beat(1'b1, -20000, 32'd100, 0));
        send_beat(tick_beat(1'b1, -32768, 32'd102, 0));
        send_beat(tick_beat(1'b1, 800, 32'd103, 0));
    endtask

    task automatic test_second_target();
        send_beat(tick_beat(1'b1, -800, 32'd104, 0));
        send_beat(tick_beat(1'b1, -800, 32'd105, -524288));
        // targets change while the second phase is already armed
        write_limits(directed_limits(16'd10, 8'd2, 32'd8000));
        send_beat(tick_beat(1'b1, 32767, 32'd106, 0));
        send_beat(tick_beat(1'b1, -800, 32'd107, 524287));
        send_beat(tick_beat(1'b1, -790, 32'd108, 0));
        send_beat(tick_beat(1'b1, -805, 32'd109, -3));
    endtask

    task automatic test_restart_extremes();
        send_beat(start_beat(1'b0));
        send_beat(tick_beat(1'b1, 0, 32'd200, 0));
        send_beat(tick_beat(1'b1, -32768, 32'd201, 0));
        send_beat(tick_beat(1'b1, 32767, 32'd202, 0));
        send_beat(tick_beat(1'b1, 0, 32'd203, 0));
        send_beat(tick_beat(1'b1, 32767, 32'd204, 0));
    endtask

    task automatic test_phase_timeout();
        write_limits(directed_limits(16'd10, 8'd2, 32'd0));
        send_beat(tick_beat(1'b1, -32768, 32'd205, 0));
        send_beat(start_beat(1'b1));
        send_beat(start_beat(1'b0));
        send_beat(tick_beat(1'b1, 32767, 32'd206, 0));
        send_beat(tick_beat(1'b1, 32767, 32'd207, 0));
    endtask

    task automatic test_zero_settle();
        write_limits(directed_limits(16'd0, 8'd0, 32'd8000));
        send_beat(start_beat(1'b0));
        send_beat(tick_beat(1'b1, 0, 32'd300, 0));
        send_beat(tick_beat(1'b1, 32757, 32'd301, 0));
        send_beat(tick_beat(1'b1, 0, 32'd302, 0));
        send_beat(tick_beat(1'b1, -32763, 32'd303, -524287));
    endtask

    task automatic test_settle_count_saturation();
        limits_t l;
        int      k;
        l.first_pos   = 16'sd0;
        l.second_pos  = 16'sd0;
        l.tol         = 16'd65535;
        l.speed       = 19'd524287;
        l.dwell_ms    = 16'd1600;
        l.min_samples = 8'd255;
        l.timeout_ms  = 32'hFFFF_FFFF;
        write_limits(l);
        send_beat(start_beat(1'b0));
        k = 0;
        while (sq_phase != tpss_pkg::PHASE_CODE_DONE && k < 400) begin
            stamp_ctr = stamp_ctr + 1;
            send_beat(tick_beat(1'b1, int'($signed(16'($urandom))), stamp_ctr,
                                int'($urandom_range(0, 1048574)) - 524287));
            k++;
        end
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_request = 120;
        drive_runs(40, 5);
        idle_on = 1'b1;
    endtask

    task automatic test_random_runs();
        limits_t l;
        for (int r = 0; r < 7; r++) begin
            write_limits(pick_limits());
            idle_on = (r % 3) != 2;
            drive_runs(45, 5);
            wait_drained();
            drive_runs(45, 5);
        end
        idle_on = 1'b1;
        l = pick_limits();
        l.tol = 16'd0;
        l.speed = 19'd0;
        l.dwell_ms = 16'd0;
        l.min_samples = 8'd0;
        l.timeout_ms = 32'd300;
        write_limits(l);
        drive_runs(60, 5);
        l = pick_limits();
        l.dwell_ms = 16'd65535;
        l.min_samples = 8'd1;
        l.timeout_ms = 32'd0;
        write_limits(l);
        drive_runs(50, 5);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("ERROR result %0d %s: expected %0h, got %0h",
                         n_results, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        status_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_status.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR result %0d arrived with nothing outstanding", n_results);
            end else begin
                want = pending_status.pop_front();
                compare_field("task_phase", 32'(result_ch.task_phase), 32'(want.phase));
                compare_field("setpoint_write", 32'(result_ch.setpoint_write),
                              32'(want.write));
                compare_field("setpoint_value", 32'(result_ch.setpoint_value),
                              32'(want.setpoint));
                compare_field("run_time_ms", result_ch.run_time_ms, want.run_time);
                compare_field("peak_error_first", 32'(result_ch.peak_error_first),
                              32'(want.peak_first));
                compare_field("peak_error_second", 32'(result_ch.peak_error_second),
                              32'(want.peak_second));
            end
            n_results++;
        end
    end

    // result side: random stall per beat, plus an occasional long hold
    initial begin
        int stall;
        int hold;
        result_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tpss_pkg::REG_FIRST_TARGET;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = tpss_pkg::CMD_TICK;
        item_ch.calibration_busy = 1'b0;
        item_ch.sample_valid = 1'b0;
        item_ch.sample_position = '0;
        item_ch.sample_stamp = '0;
        item_ch.sample_velocity = '0;
        lim.first_pos = tpss_pkg::RST_FIRST_TARGET;
        lim.second_pos = tpss_pkg::RST_SECOND_TARGET;
        lim.tol = tpss_pkg::RST_POSITION_TOLERANCE;
        lim.speed = tpss_pkg::RST_SPEED_LIMIT;
        lim.dwell_ms = tpss_pkg::RST_SETTLE_TIME_MS;
        lim.min_samples = tpss_pkg::RST_SETTLE_MIN_SAMPLES;
        lim.timeout_ms = tpss_pkg::RST_PHASE_TIMEOUT_MS;
        sq_phase = tpss_pkg::PHASE_CODE_IDLE;
        sq_time = '0;
        sq_run_start = '0;
        sq_phase_start = '0;
        sq_settle_start = '0;
        sq_last_stamp = '0;
        sq_settle_cnt = '0;
        sq_armed = 1'b0;
        sq_run_time = '0;
        sq_peak1 = '0;
        sq_peak2 = '0;
        sq_setpoint = '0;
        stamp_ctr = $urandom;
        idle_on = 1'b1;
        hold_request = 0;
        n_items = 0;
        n_results = 0;
        n_mismatch = 0;
        n_done = 0;
        n_fault = 0;
        n_ignored = 0;
        n_cfg_sets = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_gating();
        test_first_target();
        test_second_target();
        test_restart_extremes();
        test_phase_timeout();
        test_zero_settle();
        test_settle_count_saturation();
        test_backpressure();
        wait_drained();
        test_random_runs();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d beats, checked %0d status beats under %0d limit settings",
                 n_items, n_results, n_cfg_sets);
        $display("Runs settled: %0d, runs timed out: %0d, starts ignored: %0d",
                 n_done, n_fault, n_ignored);
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
